[src/mvt_pkg.sv]
// Types and constants shared by the 4x4 matrix-vector transform unit.
package mvt_pkg;

    localparam int VEC_N      = 4;
    localparam int SLOT_N     = 16;
    localparam int CMD_DEPTH  = 2;
    localparam int RES_DEPTH  = 4;

    typedef logic signed [31:0] t_q32;
    typedef logic signed [63:0] t_p64;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_XFORM = 1'b1
    } t_mode;

    typedef struct packed {
        logic       mode;
        logic [3:0] entry_index;
        t_q32       entry_value;
        t_q32       vec_x;
        t_q32       vec_y;
        t_q32       vec_z;
        t_q32       vec_w;
    } t_in_word;

    typedef struct packed {
        t_q32 out_x;
        t_q32 out_y;
        t_q32 out_z;
        t_q32 out_w;
        logic overflow;
    } t_out_word;

    typedef struct packed {
        logic                   is_load;
        logic [3:0]             index;
        t_q32                   value;
        t_q32 [VEC_N-1:0]       vec;
    } t_cmd;

endpackage

[src/matrix4x4_vector_transform_unit.sv]
// Top level of the homogeneous 4x4 matrix-vector transform unit.
//
//   channel   ports                      word        accepted when
//   input     push, full, i_data         t_in_word   push && !full
//   result    empty, pop, o_data         t_out_word  pop && !empty
//
// One input word per cycle while full is low, load or transform; one result word
// per cycle while empty is low. An accepted transform passes the command queue,
// the sixteen-multiplier stage, the pair-sum stage and the result queue to o_data.
// Reset loads the identity matrix and empties both queues.
// With pop low the four-word result queue fills, then the two-word command
// queue, then full rises; a load at the head of the command queue still drains.
module matrix4x4_vector_transform_unit #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mvt_pkg::t_in_word  i_data,
    output logic               empty,
    input  logic               pop,
    output mvt_pkg::t_out_word o_data
);
    import mvt_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    mvt_front #(
        .DIM (DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (i_data),
        .o_full      (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mvt_back #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data      (o_data)
    );

endmodule

[src/mvt_fifo.sv]
// Small register queue with count, power-of-two depth.
module mvt_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  T                             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output T                             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    T                r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            push_fire;
    logic            pop_fire;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_data    = r_mem[r_rd];
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_fire) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop_fire) begin
                r_rd <= r_rd + AW'(1);
            end
            if (push_fire && !pop_fire) begin
                r_count <= r_count + CW'(1);
            end else if (pop_fire && !push_fire) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[src/mvt_front.sv]
// Front end: accepts input words, classifies them and queues commands.
module mvt_front #(
    parameter int DIM = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mvt_pkg::t_in_word i_data,
    output logic              o_full,
    output logic              o_cmd_valid,
    output mvt_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);
    import mvt_pkg::*;

    t_cmd  cmd;
    logic  keep;
    logic  cmd_empty;
    logic  [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

    // drop loads to slots outside the active matrix
    always_comb begin
        cmd.is_load = (i_data.mode == MODE_LOAD);
        cmd.index   = i_data.entry_index;
        cmd.value   = i_data.entry_value;
        cmd.vec[0]  = i_data.vec_x;
        cmd.vec[1]  = i_data.vec_y;
        cmd.vec[2]  = i_data.vec_z;
        cmd.vec[3]  = i_data.vec_w;
        keep = !cmd.is_load
            || ((int'(i_data.entry_index[3:2]) < DIM) && (int'(i_data.entry_index[1:0]) < DIM));
    end

    mvt_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (cmd),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    assign o_cmd_valid = !cmd_empty && (cmd_count != '0);

endmodule

[src/mvt_back.sv]
// Back end: matrix store, multiply/sum/saturate pipeline and result queue.
module mvt_back #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  mvt_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output mvt_pkg::t_out_word o_data
);
    import mvt_pkg::*;

    localparam int   RES_CW = $clog2(RES_DEPTH + 1);
    localparam t_q32 ONE    = t_q32'(64'sd1 <<< FRAC_BITS);

    typedef logic signed [64:0] t_s65;
    typedef logic signed [65:0] t_s66;

    t_q32        r_mat   [SLOT_N];
    logic        r_s1_valid;
    t_p64        r_prod  [VEC_N][VEC_N];
    logic        r_s2_valid;
    t_s65        r_pair  [VEC_N][2];

    t_p64        n_prod  [VEC_N][VEC_N];
    t_s65        n_pair  [VEC_N][2];
    t_q32        sat     [VEC_N];
    logic [VEC_N-1:0] ovf;
    t_out_word   res;

    logic              res_full;
    logic [RES_CW-1:0] res_count;
    logic [RES_CW:0]   occ;
    logic              pop_fire;
    logic              credit_ok;
    logic              cmd_fire;
    logic              load_fire;
    logic              xform_fire;

    // reserve a result slot for every transform in flight
    always_comb begin
        pop_fire   = i_pop && !o_empty;
        occ        = (RES_CW+1)'(res_count) + (RES_CW+1)'(r_s1_valid)
                   + (RES_CW+1)'(r_s2_valid);
        credit_ok  = (occ < (RES_CW+1)'(RES_DEPTH)) || pop_fire;
        cmd_fire   = i_cmd_valid && (i_cmd.is_load || credit_ok);
        load_fire  = cmd_fire && i_cmd.is_load;
        xform_fire = cmd_fire && !i_cmd.is_load;
        o_cmd_pop  = cmd_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_N; s++) begin
                r_mat[s] <= ((s / VEC_N) == (s % VEC_N) && (s / VEC_N) < DIM) ? ONE : '0;
            end
        end else if (load_fire) begin
            r_mat[i_cmd.index] <= i_cmd.value;
        end
    end

    always_comb begin
        for (int r = 0; r < VEC_N; r++) begin
            for (int c = 0; c < VEC_N; c++) begin
                if (r < DIM && c < DIM) begin
                    n_prod[r][c] = t_p64'(r_mat[r*VEC_N+c]) * t_p64'(i_cmd.vec[c]);
                end else begin
                    n_prod[r][c] = '0;
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < VEC_N; r++) begin
            for (int h = 0; h < 2; h++) begin
                n_pair[r][h] = t_s65'(r_prod[r][2*h] >>> FRAC_BITS)
                             + t_s65'(r_prod[r][2*h+1] >>> FRAC_BITS);
            end
        end
    end

    always_comb begin
        t_s66 sum;
        sum = '0;
        for (int r = 0; r < VEC_N; r++) begin
            sum = t_s66'(r_pair[r][0]) + t_s66'(r_pair[r][1]);
            if (sum > t_s66'(64'sh7FFF_FFFF)) begin
                sat[r] = 32'sh7FFF_FFFF;
                ovf[r] = 1'b1;
            end else if (sum < -t_s66'(64'sh8000_0000)) begin
                sat[r] = 32'sh8000_0000;
                ovf[r] = 1'b1;
            end else begin
                sat[r] = sum[31:0];
                ovf[r] = 1'b0;
            end
        end
        res.out_x    = sat[0];
        res.out_y    = sat[1];
        res.out_z    = sat[2];
        res.out_w    = sat[3];
        res.overflow = |ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= xform_fire;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pair <= n_pair;
    end

    mvt_fifo #(
        .T     (t_out_word),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid && !res_full),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_data),
        .o_empty (o_empty),
        .o_count (res_count)
    );

endmodule
